[src/skq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skq_pkg: shared types and codes for the sorted key index queue
// Holds the entry and command words passed along the cell chain, the field
// widths and the result status codes.
// ----------------------------------------------------------------------------
package skq_pkg;

    localparam int KEY_W = 20;
    localparam int POS_W = 16;
    localparam int OCC_W = 9;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } entry_t;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } cmd_t;

endpackage
`default_nettype wire

[src/sorted_key_index_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_index_queue: insertion-sorted priority queue of key/position pairs
// The result word appears with done in the cycle after start is taken.
// Throughput: one word per cycle; every cell compares against the broadcast
// key at once and shifts one place, so busy stays low.
// The receiver cannot stall: each result is on the ports for one cycle only.
// Reset clears the valid flags, the entry count and the done strobe.
// ----------------------------------------------------------------------------
module sorted_key_index_queue #(
    parameter int CAPACITY = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          func,
    input  wire logic [skq_pkg::KEY_W-1:0]     sort_key,
    input  wire logic [skq_pkg::POS_W-1:0]     record_position,
    output logic                               done,
    output logic [skq_pkg::STATUS_W-1:0]       status,
    output logic [skq_pkg::KEY_W-1:0]          out_key,
    output logic [skq_pkg::POS_W-1:0]          out_position,
    output logic [skq_pkg::OCC_W-1:0]          occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Count register and its zero-extended form for the 9-bit occupancy port.
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W+skq_pkg::OCC_W-1:0] count_ext;

    logic                          done_reg;
    logic                          done_next;
    logic [skq_pkg::STATUS_W-1:0]  status_reg;
    logic [skq_pkg::STATUS_W-1:0]  status_next;
    logic [skq_pkg::KEY_W-1:0]     out_key_reg;
    logic [skq_pkg::KEY_W-1:0]     out_key_next;
    logic [skq_pkg::POS_W-1:0]     out_position_reg;
    logic [skq_pkg::POS_W-1:0]     out_position_next;

    logic            accept;
    logic            full;
    logic            empty;
    skq_pkg::cmd_t   cmd;
    skq_pkg::entry_t entries [CAPACITY];
    logic            lts     [CAPACITY];
    skq_pkg::entry_t empty_entry;

    // Every word is taken as it arrives, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign empty_entry.valid = 1'b0;
    assign empty_entry.key   = '0;
    assign empty_entry.pos   = '0;

    // Broadcast the command to all cells; drop an insert into a full table
    // and a remove from an empty one before they reach the chain.
    assign cmd.ins = accept && (func == skq_pkg::FUNC_INSERT) && !full;
    assign cmd.rem = accept && (func == skq_pkg::FUNC_REMOVE) && !empty;
    assign cmd.key = sort_key;
    assign cmd.pos = record_position;

    // Chain of cells: slot 0 holds the smallest key. The head sees a left
    // neighbor that is always "below" the new key so it can take the new
    // pair; the tail sees an empty right neighbor so a remove clears it.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skq_pkg::entry_t left_entry;
        logic            left_lt;
        skq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = empty_entry;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = entries[i-1];
            assign left_lt    = lts[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = empty_entry;
        end
        else
        begin : g_inner
            assign right_entry = entries[i+1];
        end

        skq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .lt          (lts[i])
        );
    end

    // Result word and count update.
    always_comb
    begin
        done_next         = accept;
        count_next        = count_reg;
        status_next       = skq_pkg::ST_DONE;
        out_key_next      = '0;
        out_position_next = '0;
        if (accept)
        begin
            unique case (func)
                skq_pkg::FUNC_INSERT:
                begin
                    if (full)
                    begin
                        status_next = skq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                skq_pkg::FUNC_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = skq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Head of the chain is the smallest pair.
                        out_key_next      = entries[0].key;
                        out_position_next = entries[0].pos;
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = skq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        out_key_reg      <= out_key_next;
        out_position_reg <= out_position_next;
    end

    assign count_ext    = {{skq_pkg::OCC_W{1'b0}}, count_reg};
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_key      = out_key_reg;
    assign out_position = out_position_reg;
    assign occupancy    = count_ext[skq_pkg::OCC_W-1:0];

endmodule
`default_nettype wire

[src/skq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skq_cell: one slot of the sorted chain
// Holds one key/position pair; on insert it holds, takes the new pair or takes
// its left neighbor; on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module skq_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire skq_pkg::cmd_t   cmd,
    input  wire skq_pkg::entry_t left_entry,
    input  wire logic            left_lt,
    input  wire skq_pkg::entry_t right_entry,
    output skq_pkg::entry_t      entry,
    output logic                 lt
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [skq_pkg::KEY_W-1:0] key_reg;
    logic [skq_pkg::KEY_W-1:0] key_next;
    logic [skq_pkg::POS_W-1:0] pos_reg;
    logic [skq_pkg::POS_W-1:0] pos_next;

    // Own key is below the new key: this slot stays where it is.
    assign lt = valid_reg && (key_reg < cmd.key);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.pos   = pos_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        priority if (cmd.ins)
        begin
            if (lt)
            begin
                // hold
            end
            else if (left_lt)
            begin
                valid_next = 1'b1;
                key_next   = cmd.key;
                pos_next   = cmd.pos;
            end
            else
            begin
                valid_next = left_entry.valid;
                key_next   = left_entry.key;
                pos_next   = left_entry.pos;
            end
        end
        else if (cmd.rem)
        begin
            valid_next = right_entry.valid;
            key_next   = right_entry.key;
            pos_next   = right_entry.pos;
        end
        else
        begin
            // idle: hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

endmodule
`default_nettype wire
